// ----- hdl/word_wrap_break_finder_unit_defines.svh -----
// Shared assertion macros for the word wrap break finder.
`ifndef WORD_WRAP_BREAK_FINDER_UNIT_DEFINES_SVH
`define WORD_WRAP_BREAK_FINDER_UNIT_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define WWBF_ASSERT_SAME(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wwbf assertion failed");

// Check that a condition implies another in the following cycle.
`define WWBF_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wwbf assertion failed");

`endif

// ----- hdl/wwbf_pkg.sv -----
package wwbf_pkg;

  localparam int COL_BITS = 11;
  localparam int LW_BITS  = 10;
  localparam int TS_BITS  = 5;
  localparam int CFG_DATA_BITS = 10;

  localparam logic [LW_BITS-1:0] LINE_WIDTH_RESET = 10'd80;
  localparam logic [TS_BITS-1:0] TAB_SIZE_RESET   = 5'd8;

  // Register indexes on the configuration port
  localparam logic CFG_LINE_WIDTH = 1'b0;
  localparam logic CFG_TAB_SIZE   = 1'b1;

  // A tab shown as a control character takes two cells
  localparam logic [COL_BITS-1:0] CTRL_TAB_CELLS = 11'd2;

  // Remainder unit: dividend digits retired per cycle, and number of digit-group steps
  localparam int REM_DIGITS = 3;
  localparam int REM_STEPS  = (COL_BITS + REM_DIGITS - 1) / REM_DIGITS;
  localparam int REM_PAD    = REM_STEPS * REM_DIGITS;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_UPDATE
  } wwbf_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } wwbf_cmd_t;

  typedef struct packed {
    logic need_div;
    logic rem_done;
    logic out_free;
  } wwbf_status_t;

endpackage

// ----- hdl/wwbf_rem.sv -----
module wwbf_rem
  import wwbf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [COL_BITS-1:0] dividend,
  input  logic [TS_BITS-1:0]  divisor,
  output logic [TS_BITS-1:0]  remainder,
  output logic                done
);

  localparam int CNT_BITS = $clog2(REM_STEPS);

  logic [REM_PAD-1:0]  digits;
  logic [CNT_BITS-1:0] count;
  logic                busy;
  logic [TS_BITS-1:0]  remainder_next;

  // Retire REM_DIGITS dividend bits with restoring compare and subtract
  always_comb begin
    logic [TS_BITS:0] trial;
    remainder_next = remainder;
    for (int k = 0; k < REM_DIGITS; k++) begin
      trial = {remainder_next, digits[REM_PAD-1-k]};
      if (trial >= {1'b0, divisor}) begin
        trial = trial - {1'b0, divisor};
      end
      remainder_next = trial[TS_BITS-1:0];
    end
  end

  // Load on start, then advance one digit group per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy      <= 1'b1;
      done      <= 1'b0;
      count     <= '0;
      remainder <= '0;
      digits    <= {{(REM_PAD-COL_BITS){1'b0}}, dividend};
    end else if (busy) begin
      remainder <= remainder_next;
      digits    <= digits << REM_DIGITS;
      count     <= count + 1'b1;
      if (count == CNT_BITS'(REM_STEPS-1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

// ----- hdl/wwbf_ctrl.sv -----
module wwbf_ctrl
  import wwbf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  wwbf_status_t sts,
  output wwbf_cmd_t    cmd,
  output logic         in_stall
);

  wwbf_state_t state, state_next;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = sts.need_div ? ST_DIVIDE : ST_UPDATE;
        end
      end
      ST_DIVIDE: begin
        if (sts.rem_done) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_DIVIDE: begin
        in_stall = 1'b1;
      end
      ST_UPDATE: begin
        cmd.commit = sts.out_free;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/wwbf_dpath.sv -----
module wwbf_dpath
  import wwbf_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     first_of_line,
  input  logic                     last_of_line,
  input  logic                     lead_combining,
  input  logic [POSITION_BITS-1:0] char_pos,
  input  logic [POSITION_BITS-1:0] next_pos,
  input  logic                     is_tab,
  input  logic                     is_control,
  input  logic [1:0]               cell_width,
  input  logic                     is_graphic,
  input  logic                     is_alnum,
  input  logic                     is_space,
  input  logic                     out_stall,
  input  wwbf_cmd_t                cmd,
  output wwbf_status_t             sts,
  output logic                     out_valid,
  output logic                     break_found,
  output logic                     char_cut,
  output logic signed [POSITION_BITS:0] break_pos
);

  // Configuration
  logic [LW_BITS-1:0] line_width;
  logic [TS_BITS-1:0] tab_size;

  // Scan state
  logic [COL_BITS-1:0]      column_total;
  logic [POSITION_BITS-1:0] candidate_pos;
  logic                     visible_seen;
  logic                     prev_visible;
  logic                     scan_done;

  // Captured item
  logic                     item_first;
  logic                     item_last;
  logic [COL_BITS-1:0]      item_col;
  logic [POSITION_BITS-1:0] item_pos;
  logic [POSITION_BITS-1:0] item_next;
  logic                     item_tab;
  logic                     item_ctrl;
  logic [1:0]               item_cells;
  logic                     item_graph;
  logic                     item_alnum;
  logic                     item_space;

  logic [COL_BITS-1:0] col_in;
  logic [TS_BITS-1:0]  rem;
  logic                rem_done;

  // Per-item results
  logic                     active;
  logic                     emit;
  logic                     res_found;
  logic                     res_partial;
  logic [POSITION_BITS:0]   res_pos;
  logic [COL_BITS-1:0]      col_next;
  logic [POSITION_BITS-1:0] cand_next;
  logic                     gs_next;
  logic                     lwg_next;

  // Starting column of the incoming item
  assign col_in = first_of_line ? {{(COL_BITS-1){1'b0}}, lead_combining} : column_total;

  wwbf_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.capture),
    .dividend  (col_in),
    .divisor   (tab_size),
    .remainder (rem),
    .done      (rem_done)
  );

  assign sts.need_div = is_tab && (tab_size != '0);
  assign sts.rem_done = rem_done;
  assign sts.out_free = !out_valid || !out_stall;

  // Evaluate the captured item against the scan state
  always_comb begin
    logic [POSITION_BITS-1:0] cand0;
    logic                     gs0;
    logic                     lwg0;
    logic [COL_BITS-1:0]      adv;
    logic [COL_BITS-1:0]      col1;
    logic                     visible;
    logic [POSITION_BITS-1:0] cand1;
    logic                     gs1;
    logic                     lwg1;

    active = item_first || !scan_done;
    cand0  = item_first ? '0 : candidate_pos;
    gs0    = item_first ? 1'b0 : visible_seen;
    lwg0   = item_first ? 1'b0 : prev_visible;

    if (item_tab) begin
      adv = (tab_size != '0) ? {{(COL_BITS-TS_BITS){1'b0}}, tab_size - rem} : CTRL_TAB_CELLS;
    end else begin
      adv = {{(COL_BITS-2){1'b0}}, item_cells};
    end
    col1 = item_col + adv;

    visible = item_graph || item_ctrl;
    cand1   = cand0;
    gs1     = gs0;
    lwg1    = lwg0;
    if (!gs0) begin
      if (visible) begin
        gs1  = 1'b1;
        lwg1 = 1'b1;
      end else begin
        cand1 = item_pos;
      end
    end else if (item_space && lwg0) begin
      cand1 = item_next;
      lwg1  = 1'b0;
    end else if (visible) begin
      if (lwg0 && !item_alnum) begin
        cand1 = item_next;
      end
      lwg1 = 1'b1;
    end

    emit        = 1'b0;
    res_found   = 1'b1;
    res_partial = 1'b0;
    res_pos     = '1;
    col_next    = col1;
    cand_next   = cand1;
    gs_next     = gs1;
    lwg_next    = lwg1;

    if (item_col >= {1'b0, line_width}) begin
      // Line already full on arrival
      emit      = 1'b1;
      res_pos   = {1'b0, (cand0 != '0) ? cand0 : item_pos};
      col_next  = item_col;
      cand_next = cand0;
      gs_next   = gs0;
      lwg_next  = lwg0;
    end else if (col1 > {1'b0, line_width} && (!item_tab || tab_size == '0)) begin
      // Character crosses the edge
      emit        = 1'b1;
      res_partial = (cand0 == '0);
      res_pos     = {1'b0, (cand0 != '0) ? cand0 : item_pos};
      cand_next   = cand0;
      gs_next     = gs0;
      lwg_next    = lwg0;
    end else if (item_last) begin
      emit      = 1'b1;
      res_found = 1'b0;
    end else if (col1 >= {1'b0, line_width}) begin
      emit    = 1'b1;
      res_pos = {1'b0, (cand1 != '0) ? cand1 : item_next};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= LINE_WIDTH_RESET;
      tab_size   <= TAB_SIZE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_LINE_WIDTH: line_width <= cfg_data[LW_BITS-1:0];
        CFG_TAB_SIZE:   tab_size   <= cfg_data[TS_BITS-1:0];
        default:        ;
      endcase
    end
  end

  // Capture the item on transfer
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_first <= first_of_line;
      item_last  <= last_of_line;
      item_col   <= col_in;
      item_pos   <= char_pos;
      item_next  <= next_pos;
      item_tab   <= is_tab;
      item_ctrl  <= is_control;
      item_cells <= cell_width;
      item_graph <= is_graphic;
      item_alnum <= is_alnum;
      item_space <= is_space;
    end
  end

  // Advance the scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      column_total  <= '0;
      candidate_pos <= '0;
      visible_seen  <= 1'b0;
      prev_visible  <= 1'b0;
      scan_done     <= 1'b1;
    end else if (cmd.commit && active) begin
      column_total  <= col_next;
      candidate_pos <= cand_next;
      visible_seen  <= gs_next;
      prev_visible  <= lwg_next;
      scan_done     <= emit;
    end
  end

  // Output register: load a result, drop it once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit && active && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && active && emit) begin
      break_found <= res_found;
      char_cut    <= res_partial;
      break_pos   <= res_pos;
    end
  end

endmodule

// ----- hdl/word_wrap_break_finder_unit.sv -----
// Flow: an input transfer is captured in IDLE, a tab with nonzero tab size then waits
// in DIVIDE for the digit-serial tab-stop remainder unit, and UPDATE commits the result.
// One item at a time: a new item is taken only in IDLE; a waiting result lets
// one more transfer in, which then holds until the result is transferred.
// Reset (rst, synchronous): line_width 80, tab_size 8, no scan in progress,
// output empty.
`include "word_wrap_break_finder_unit_defines.svh"

module word_wrap_break_finder_unit
  import wwbf_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     first_of_line,
  input  logic                     last_of_line,
  input  logic                     lead_combining,
  input  logic [POSITION_BITS-1:0] char_pos,
  input  logic [POSITION_BITS-1:0] next_pos,
  input  logic                     is_tab,
  input  logic                     is_control,
  input  logic [1:0]               cell_width,
  input  logic                     is_graphic,
  input  logic                     is_alnum,
  input  logic                     is_space,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     break_found,
  output logic                     char_cut,
  output logic signed [POSITION_BITS:0] break_pos
);

  wwbf_cmd_t    cmd;
  wwbf_status_t sts;

  wwbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  wwbf_dpath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .first_of_line  (first_of_line),
    .last_of_line   (last_of_line),
    .lead_combining (lead_combining),
    .char_pos       (char_pos),
    .next_pos       (next_pos),
    .is_tab         (is_tab),
    .is_control     (is_control),
    .cell_width     (cell_width),
    .is_graphic     (is_graphic),
    .is_alnum       (is_alnum),
    .is_space       (is_space),
    .out_stall      (out_stall),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .break_found    (break_found),
    .char_cut       (char_cut),
    .break_pos      (break_pos)
  );

  // One item at a time: busy right after a transfer
  `WWBF_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall)
  // A line that fits reports no position and no cut character
  `WWBF_ASSERT_SAME(a_fit_no_pos, out_valid && !break_found, break_pos == '1 && !char_cut)
  // A cut character only comes with a break
  `WWBF_ASSERT_SAME(a_partial_breaks, out_valid && char_cut, break_found)

endmodule

// ----- verif/word_wrap_break_finder_unit_tb.sv -----
module word_wrap_break_finder_unit_tb
  import wwbf_pkg::*;
();

  localparam int IDLE_PCT      = 27;
  localparam int NOISE_PCT     = 8;
  localparam int RESTART_PCT   = 2;
  localparam int RANDOM_ITEMS  = 480;
  localparam int PHASE_ITEMS   = 50;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT     = 2000000;
  localparam logic [16:0] NO_BREAK = 17'h1FFFF;

  typedef struct packed {
    logic        first;
    logic        last;
    logic        lead;
    logic [15:0] char_pos;
    logic [15:0] next_pos;
    logic        is_tab;
    logic        is_control;
    logic [1:0]  cell_width;
    logic        is_graphic;
    logic        is_alnum;
    logic        is_space;
  } glyph_t;

  typedef struct packed {
    logic        found;
    logic        partial;
    logic [16:0] pos;
  } break_rec_t;

  typedef enum logic [1:0] {SCAN_IGNORED, SCAN_RUNNING, SCAN_ENDED} scan_step_t;
  typedef enum logic [1:0] {CHK_MODEL, CHK_TYPED, CHK_NONE} row_check_t;
  typedef enum logic [2:0] {
    GL_LETTER, GL_WIDE, GL_PUNCT, GL_SPACE, GL_TAB, GL_CTRL, GL_MARK, GL_ODD
  } glyph_class_t;

  typedef struct {
    bit          setup;
    logic [9:0]  line_w;
    logic [4:0]  tab_w;
    glyph_t      g;
    row_check_t  chk;
    break_rec_t  want;
  } plan_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_write;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     in_valid;
  logic                     in_stall;
  logic                     first_of_line;
  logic                     last_of_line;
  logic                     lead_combining;
  logic [15:0]              char_pos;
  logic [15:0]              next_pos;
  logic                     is_tab;
  logic                     is_control;
  logic [1:0]               cell_width;
  logic                     is_graphic;
  logic                     is_alnum;
  logic                     is_space;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     break_found;
  logic                     char_cut;
  logic signed [16:0]       break_pos;

  // Predicted scan state and register copies
  logic [10:0] col_total;
  logic [15:0] cand_pos;
  logic        seen_visible;
  logic        last_graph;
  logic        scan_done;
  logic [9:0]  lw_cfg;
  logic [4:0]  ts_cfg;

  break_rec_t  expected_breaks[$];
  plan_row_t   plan[$];

  bit          sender_quiet;
  bit          hold_request;
  int          hold_left;
  int unsigned rx_cycle;
  int unsigned fail_count;
  int unsigned transfers;
  int unsigned setups_done;
  int unsigned results_checked;
  int unsigned fits_seen;
  int unsigned breaks_seen;
  int unsigned cuts_seen;

  word_wrap_break_finder_unit DUT (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .first_of_line  (first_of_line),
    .last_of_line   (last_of_line),
    .lead_combining (lead_combining),
    .char_pos       (char_pos),
    .next_pos       (next_pos),
    .is_tab         (is_tab),
    .is_control     (is_control),
    .cell_width     (cell_width),
    .is_graphic     (is_graphic),
    .is_alnum       (is_alnum),
    .is_space       (is_space),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .break_found    (break_found),
    .char_cut       (char_cut),
    .break_pos      (break_pos)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Append a result to the list still owed by the block
  function automatic void queue_break(input break_rec_t r);
    expected_breaks.insert(expected_breaks.size(), r);
  endfunction

  // Append a row to the directed table
  function automatic void add_row(input plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  // End the scan and form its result
  function automatic break_rec_t close_scan(input logic found, input logic partial,
                                            input logic [16:0] at);
    break_rec_t r;
    r.found   = found;
    r.partial = partial;
    r.pos     = at;
    scan_done = 1'b1;
    return r;
  endfunction

  // Advance the predicted scan by one cursor stop
  function automatic scan_step_t predict_break(input glyph_t g, output break_rec_t res);
    int   adv;
    logic visible;
    res = '0;
    if (g.first) begin
      col_total    = g.lead ? 11'd1 : 11'd0;
      cand_pos     = '0;
      seen_visible = 1'b0;
      last_graph   = 1'b0;
      scan_done    = 1'b0;
    end else if (scan_done) begin
      return SCAN_IGNORED;
    end

    // Line already full when the stop arrives
    if (col_total >= lw_cfg) begin
      res = close_scan(1'b1, 1'b0, {1'b0, (cand_pos != 0) ? cand_pos : g.char_pos});
      return SCAN_ENDED;
    end

    // Advance the column; tabs go to the next stop or count as control
    if (g.is_tab)
      adv = (ts_cfg != 0) ? int'(ts_cfg) - int'(col_total % ts_cfg) : int'(CTRL_TAB_CELLS);
    else
      adv = int'(g.cell_width);
    col_total = 11'(int'(col_total) + adv);

    // Overflow cuts here unless it is a stop-aligned tab
    if (col_total > lw_cfg && (!g.is_tab || ts_cfg == 0)) begin
      res = close_scan(1'b1, cand_pos == 0,
                       {1'b0, (cand_pos == 0) ? g.char_pos : cand_pos});
      return SCAN_ENDED;
    end

    // Track break candidates across class transitions
    visible = g.is_graphic | g.is_control;
    if (!seen_visible) begin
      if (visible) begin
        seen_visible = 1'b1;
        last_graph   = 1'b1;
      end else begin
        cand_pos = g.char_pos;
      end
    end else if (g.is_space && last_graph) begin
      cand_pos   = g.next_pos;
      last_graph = 1'b0;
    end else if (visible) begin
      if (last_graph && !g.is_alnum)
        cand_pos = g.next_pos;
      last_graph = 1'b1;
    end

    if (g.last) begin
      res = close_scan(1'b0, 1'b0, NO_BREAK);
      return SCAN_ENDED;
    end
    if (col_total >= lw_cfg) begin
      res = close_scan(1'b1, 1'b0, {1'b0, (cand_pos != 0) ? cand_pos : g.next_pos});
      return SCAN_ENDED;
    end
    return SCAN_RUNNING;
  endfunction

  // Character class bits for a glyph kind, positions left at zero
  function automatic glyph_t class_glyph(input glyph_class_t cls);
    glyph_t g;
    g = '0;
    case (cls)
      GL_LETTER: begin
        g.is_graphic = 1'b1; g.is_alnum = 1'b1; g.cell_width = 2'd1;
      end
      GL_WIDE: begin
        g.is_graphic = 1'b1; g.is_alnum = 1'b1; g.cell_width = 2'd2;
      end
      GL_PUNCT: begin
        g.is_graphic = 1'b1; g.cell_width = 2'd1;
      end
      GL_SPACE: begin
        g.is_space = 1'b1; g.cell_width = 2'd1;
      end
      GL_TAB: begin
        g.is_tab = 1'b1; g.is_control = 1'b1; g.is_space = 1'b1; g.cell_width = 2'd2;
      end
      GL_CTRL: begin
        g.is_control = 1'b1; g.cell_width = 2'd2;
      end
      GL_MARK: begin
        g.cell_width = 2'd0;
      end
      default: begin
        g.is_graphic = 1'b1; g.is_space = 1'b1; g.cell_width = 2'd3;
      end
    endcase
    return g;
  endfunction

  function automatic plan_row_t row(input glyph_class_t cls, input logic first,
                                    input logic last, input logic lead,
                                    input logic [15:0] at, input logic [15:0] nxt,
                                    input row_check_t chk, input logic found,
                                    input logic partial, input logic [16:0] bpos);
    plan_row_t r;
    r.setup        = 1'b0;
    r.line_w       = '0;
    r.tab_w        = '0;
    r.g            = class_glyph(cls);
    r.g.first      = first;
    r.g.last       = last;
    r.g.lead       = lead;
    r.g.char_pos   = at;
    r.g.next_pos   = nxt;
    r.chk          = chk;
    r.want.found   = found;
    r.want.partial = partial;
    r.want.pos     = bpos;
    return r;
  endfunction

  function automatic plan_row_t setup_row(input logic [9:0] lw, input logic [4:0] ts);
    plan_row_t r;
    r.setup  = 1'b1;
    r.line_w = lw;
    r.tab_w  = ts;
    r.g      = '0;
    r.chk    = CHK_NONE;
    r.want   = '0;
    return r;
  endfunction

  // Offer one cursor stop, with random idle cycles ahead unless the sender is quiet, and hold until transfer
  task automatic offer_glyph(input glyph_t g);
    if (!sender_quiet) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    first_of_line  <= g.first;
    last_of_line   <= g.last;
    lead_combining <= g.lead;
    char_pos       <= g.char_pos;
    next_pos       <= g.next_pos;
    is_tab         <= g.is_tab;
    is_control     <= g.is_control;
    cell_width     <= g.cell_width;
    is_graphic     <= g.is_graphic;
    is_alnum       <= g.is_alnum;
    is_space       <= g.is_space;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    transfers++;
  endtask

  // Drop valid, wait for all pending results, then let the block go quiet
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_breaks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both registers while the block is idle
  task automatic load_setting(input logic [9:0] lw, input logic [4:0] ts);
    settle_block();
    cfg_write <= 1'b1;
    cfg_index <= CFG_LINE_WIDTH;
    cfg_data  <= lw;
    @(posedge clk);
    cfg_index <= CFG_TAB_SIZE;
    cfg_data  <= {5'($urandom), ts};
    @(posedge clk);
    cfg_write <= 1'b0;
    lw_cfg = lw;
    ts_cfg = ts;
    setups_done++;
  endtask

  function automatic glyph_t pick_glyph(input int unsigned tab_pct);
    int unsigned  p;
    glyph_class_t cls;
    p = $urandom_range(0, 99);
    if (p < tab_pct) cls = GL_TAB;
    else begin
      p = $urandom_range(0, 99);
      if (p < 50)      cls = GL_LETTER;
      else if (p < 58) cls = GL_WIDE;
      else if (p < 72) cls = GL_PUNCT;
      else if (p < 88) cls = GL_SPACE;
      else if (p < 94) cls = GL_CTRL;
      else if (p < 97) cls = GL_MARK;
      else             cls = GL_ODD;
    end
    return class_glyph(cls);
  endfunction

  // Send one line of random text; mostly drop the rest of the line once it breaks
  task automatic scan_random_line(input int unsigned len_cap, input int unsigned tab_pct,
                                  output int unsigned counted);
    glyph_t      g;
    break_rec_t  res;
    scan_step_t  step;
    logic [15:0] at;
    logic [63:0] raw;
    logic        lead;
    int unsigned len;
    int unsigned k;
    counted = 0;
    at   = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom);
    lead = ($urandom_range(0, 7) == 0);
    len  = $urandom_range(1, len_cap);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 99) < NOISE_PCT) begin
        raw = {$urandom, $urandom};
        g   = raw[$bits(glyph_t)-1:0];
      end else begin
        g            = pick_glyph(tab_pct);
        g.first      = (k == 0) || ($urandom_range(0, 99) < RESTART_PCT);
        g.last       = (k == len - 1);
        g.lead       = lead;
        g.char_pos   = at;
        at           = at + 16'($urandom_range(1, 4));
        g.next_pos   = at;
      end
      step = predict_break(g, res);
      if (step == SCAN_ENDED) queue_break(res);
      if (step != SCAN_IGNORED) counted++;
      offer_glyph(g);
      if (step == SCAN_ENDED && $urandom_range(0, 9) != 0) break;
    end
  endtask

  function automatic void check_field(input string name, input logic [16:0] want,
                                      input logic [16:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Result side: check each transfer, then pick the stall for the next cycle
  always @(posedge clk) begin
    break_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_breaks.size() == 0) begin
        $display("%0t: unexpected result, expected none, got found %b partial %b pos %h",
                 $time, break_found, char_cut, break_pos);
        fail_count++;
      end else begin
        want = expected_breaks.pop_front();
        check_field("break_found", 17'(want.found), 17'(break_found));
        check_field("char_cut", 17'(want.partial), 17'(char_cut));
        check_field("break_pos", want.pos, break_pos);
        results_checked++;
        if (!want.found)       fits_seen++;
        else if (want.partial) cuts_seen++;
        else                   breaks_seen++;
      end
    end
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      // a recurring window with no random stalls at all
      out_stall <= ((rx_cycle % 3000) < 2000) && ($urandom_range(0, 99) < IDLE_PCT);
    end
    rx_cycle++;
  end

  initial begin
    #(RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    break_rec_t  res;
    scan_step_t  step;
    int unsigned phase;
    int unsigned random_items;
    int unsigned phase_items;
    int unsigned counted;
    int unsigned tab_pct;
    int unsigned p;
    logic [9:0]  lw;
    logic [4:0]  ts;

    rst            = 1'b1;
    cfg_write      = 1'b0;
    cfg_index      = CFG_LINE_WIDTH;
    cfg_data       = '0;
    in_valid       = 1'b0;
    first_of_line  = 1'b0;
    last_of_line   = 1'b0;
    lead_combining = 1'b0;
    char_pos       = '0;
    next_pos       = '0;
    is_tab         = 1'b0;
    is_control     = 1'b0;
    cell_width     = '0;
    is_graphic     = 1'b0;
    is_alnum       = 1'b0;
    is_space       = 1'b0;
    sender_quiet   = 1'b0;
    hold_request   = 1'b0;
    hold_left      = 0;
    rx_cycle       = 0;
    fail_count     = 0;
    transfers      = 0;
    setups_done    = 0;
    results_checked = 0;
    fits_seen      = 0;
    breaks_seen    = 0;
    cuts_seen      = 0;

    // Predicted state after reset
    lw_cfg       = LINE_WIDTH_RESET;
    ts_cfg       = TAB_SIZE_RESET;
    col_total    = '0;
    cand_pos     = '0;
    seen_visible = 1'b0;
    last_graph   = 1'b0;
    scan_done    = 1'b1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed stops; typed results where they follow directly from the rules
    add_row(row(GL_LETTER, 0, 0, 0, 16'd5, 16'd6, CHK_NONE, 0, 0, 0));
    add_row(row(GL_LETTER, 1, 1, 0, 16'd0, 16'd1, CHK_TYPED, 0, 0, NO_BREAK));
    add_row(row(GL_SPACE, 1, 0, 1, 16'd0, 16'd1, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 1, 0, 0, 16'd0, 16'd1, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_PUNCT, 0, 0, 0, 16'd1, 16'd2, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_TAB, 0, 1, 0, 16'd2, 16'd3, CHK_MODEL, 0, 0, 0));
    add_row(setup_row(10'd1, 5'd8));
    add_row(row(GL_LETTER, 1, 0, 1, 16'd0, 16'd1, CHK_TYPED, 1, 0, 17'd0));
    add_row(row(GL_WIDE, 1, 0, 0, 16'hFFFF, 16'hFFFF, CHK_TYPED, 1, 1, 17'hFFFF));
    add_row(row(GL_LETTER, 1, 0, 0, 16'd7, 16'd8, CHK_TYPED, 1, 0, 17'd8));
    add_row(row(GL_CTRL, 1, 0, 0, 16'd5, 16'd6, CHK_TYPED, 1, 1, 17'd5));
    add_row(setup_row(10'd1, 5'd0));
    add_row(row(GL_TAB, 1, 0, 0, 16'd3, 16'd4, CHK_TYPED, 1, 1, 17'd3));
    add_row(setup_row(10'd1023, 5'd16));
    add_row(row(GL_TAB, 1, 0, 0, 16'd0, 16'd1, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_ODD, 0, 0, 0, 16'd1, 16'd2, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_SPACE, 0, 1, 0, 16'd2, 16'd3, CHK_MODEL, 0, 0, 0));
    add_row(setup_row(10'd0, 5'd16));
    add_row(row(GL_LETTER, 1, 0, 0, 16'd9, 16'd10, CHK_TYPED, 1, 0, 17'd9));
    add_row(setup_row(10'd4, 5'd31));
    add_row(row(GL_LETTER, 1, 0, 0, 16'd0, 16'd1, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_TAB, 0, 0, 0, 16'd1, 16'd2, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 0, 0, 0, 16'd2, 16'd3, CHK_NONE, 0, 0, 0));
    add_row(setup_row(10'd6, 5'd4));
    add_row(row(GL_LETTER, 1, 0, 0, 16'h8000, 16'h8001, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 0, 0, 0, 16'h8001, 16'h8002, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_SPACE, 0, 0, 0, 16'h8002, 16'h8003, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 0, 0, 0, 16'h8003, 16'h8004, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 0, 0, 0, 16'h8004, 16'h8005, CHK_MODEL, 0, 0, 0));
    add_row(row(GL_LETTER, 0, 0, 0, 16'h8005, 16'h8006, CHK_MODEL, 0, 0, 0));

    foreach (plan[i]) begin
      if (plan[i].setup) begin
        load_setting(plan[i].line_w, plan[i].tab_w);
      end else begin
        step = predict_break(plan[i].g, res);
        if (plan[i].chk == CHK_TYPED)
          queue_break(plan[i].want);
        else if (plan[i].chk == CHK_MODEL && step == SCAN_ENDED)
          queue_break(res);
        offer_glyph(plan[i].g);
      end
    end

    // Random lines across a series of register settings
    phase        = 0;
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: begin lw = 10'd1023; ts = 5'd16; tab_pct = 30; end
        1: begin lw = 10'd1;    ts = 5'd0;  tab_pct = 10; end
        2: begin lw = 10'd3;    ts = 5'd2;  tab_pct = 10; end
        3: begin lw = 10'd1023; ts = 5'd31; tab_pct = 15; end
        default: begin
          p = $urandom_range(0, 9);
          if (p < 7)      lw = 10'($urandom_range(2, 40));
          else if (p < 9) lw = 10'($urandom_range(41, 200));
          else            lw = 10'($urandom_range(0, 1023));
          ts = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(1, 8));
          tab_pct = $urandom_range(0, 20);
        end
      endcase
      load_setting(lw, ts);
      sender_quiet = (phase % 4 == 1);
      // short lines back to back while the result side holds off
      if (phase == 2) begin
        hold_request = 1'b1;
        sender_quiet = 1'b1;
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
        scan_random_line((lw < 10'd56) ? int'(lw) + 4 : 80, tab_pct, counted);
        phase_items  += counted;
        random_items += counted;
      end
      phase++;
    end

    settle_block();
    $display("summary: %0d transfers under %0d register settings (%0d random phases)",
             transfers, setups_done, phase);
    $display("summary: %0d line results checked: %0d fit, %0d broken, %0d cut mid-character",
             results_checked, fits_seen, breaks_seen, cuts_seen);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
